FILE: hdl/rpl_pkg.sv
// ----------------------------------------------------------------------------
// rpl_pkg: shared types and constants of the regex pattern lexer
// Payload structs, token kind and error codes, lexer modes, and the sizes
// of the literal buffer.
// ----------------------------------------------------------------------------
package rpl_pkg;

   localparam int MAX_LITERAL = 32;
   localparam int MAX_PATTERN = 4096;

   localparam int LIT_IDX_W = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
   localparam int LIT_LEN_W = $clog2(MAX_LITERAL + 1);
   localparam int POS_W     = 12;

   localparam logic [POS_W-1:0] POS_CAP =
      POS_W'(((MAX_PATTERN - 1) < 4095) ? (MAX_PATTERN - 1) : 4095);

   // Token kinds.
   localparam logic [4:0] KIND_LIT_HEAD = 5'd0;
   localparam logic [4:0] KIND_LIT_BYTE = 5'd1;
   localparam logic [4:0] KIND_CHAR     = 5'd2;
   localparam logic [4:0] KIND_BIG_CHAR = 5'd3;
   localparam logic [4:0] KIND_ANY_CHAR = 5'd4;
   localparam logic [4:0] KIND_DIGIT    = 5'd5;
   localparam logic [4:0] KIND_NEWLINE  = 5'd6;
   localparam logic [4:0] KIND_ANY      = 5'd7;
   localparam logic [4:0] KIND_SPACE    = 5'd8;
   localparam logic [4:0] KIND_TAB      = 5'd9;
   localparam logic [4:0] KIND_PLUS     = 5'd10;
   localparam logic [4:0] KIND_STAR     = 5'd11;
   localparam logic [4:0] KIND_QUESTION = 5'd12;
   localparam logic [4:0] KIND_MINUS    = 5'd13;
   localparam logic [4:0] KIND_LBRACK   = 5'd14;
   localparam logic [4:0] KIND_RBRACK   = 5'd15;
   localparam logic [4:0] KIND_LPAREN   = 5'd16;
   localparam logic [4:0] KIND_RPAREN   = 5'd17;
   localparam logic [4:0] KIND_LCURLY   = 5'd18;
   localparam logic [4:0] KIND_RCURLY   = 5'd19;
   localparam logic [4:0] KIND_COMMA    = 5'd20;
   localparam logic [4:0] KIND_BANG     = 5'd21;
   localparam logic [4:0] KIND_OR       = 5'd22;
   localparam logic [4:0] KIND_LOWER    = 5'd23;
   localparam logic [4:0] KIND_UPPER    = 5'd24;
   localparam logic [4:0] KIND_NUMBER   = 5'd25;
   localparam logic [4:0] KIND_UNKNOWN  = 5'd26;
   localparam logic [4:0] KIND_ERROR    = 5'd27;

   // Error codes.
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
   localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd2;
   localparam logic [2:0] ERR_LIT_OVERFLOW = 3'd3;
   localparam logic [2:0] ERR_NUM_SAT      = 3'd4;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_ESC,
      MODE_LIT,
      MODE_LITESC
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] pattern_byte;
      logic       end_of_pattern;
   } req_type;

   typedef struct packed {
      logic [4:0]       token_kind;
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
      logic [15:0]      token_value;
      logic [2:0]       error_code;
      logic             last_of_run;
   } rsp_type;

   // Tokens produced by one accepted request, handed from scanner to emitter.
   typedef struct packed {
      logic [1:0]           count;
      rsp_type              tok0;
      rsp_type              tok1;
      logic                 burst;
      logic [LIT_LEN_W-1:0] burst_len;
      logic [POS_W-1:0]     burst_start;
      logic [POS_W-1:0]     burst_end;
   } lex_result_type;

   typedef struct packed {
      logic                 en;
      logic [LIT_IDX_W-1:0] addr;
      logic [7:0]           data;
   } ram_wr_type;

   typedef struct packed {
      logic             busy;
      lex_mode_type     mode;
      logic [POS_W-1:0] pos;
   } scan_status_type;

   typedef struct packed {
      logic idle;
      logic out_free;
   } emit_status_type;

endpackage

FILE: hdl/rpl_ram.sv
// ----------------------------------------------------------------------------
// rpl_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with a registered read; the read data
// holds while no read is issued.
// ----------------------------------------------------------------------------
module rpl_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                              rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rpl_scan.sv
// ----------------------------------------------------------------------------
// rpl_scan: byte scanner of the regex pattern lexer
// Tracks the lexer mode, position, number run and literal length, turns
// each accepted byte into at most two tokens, and writes literal bytes to
// the literal buffer RAM.
// ----------------------------------------------------------------------------
module rpl_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  rpl_pkg::req_type         req,
   input  logic                     skip_blanks,
   output rpl_pkg::lex_result_type  lex,
   output rpl_pkg::ram_wr_type      ram_wr,
   output rpl_pkg::scan_status_type status
);

   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LCURLY = 8'h7B;
   localparam logic [7:0] CH_RCURLY = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_LOW_C  = 8'h63;
   localparam logic [7:0] CH_UP_C   = 8'h43;
   localparam logic [7:0] CH_UP_T   = 8'h54;
   localparam logic [7:0] CH_LOW_D  = 8'h64;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam int                             LEN_W   = rpl_pkg::LIT_LEN_W;
   localparam int                             IDX_W   = rpl_pkg::LIT_IDX_W;
   localparam int                             PW      = rpl_pkg::POS_W;
   localparam logic [LEN_W-1:0]               LEN_MAX = LEN_W'(rpl_pkg::MAX_LITERAL);

   rpl_pkg::lex_mode_type mode_ff, mode_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [PW-1:0]    start_ff, start_in;
   logic [15:0]      acc_ff, acc_in;
   logic             num_ovf_ff, num_ovf_in;
   logic [PW-1:0]    num_end_ff, num_end_in;
   logic [LEN_W-1:0] lit_len_ff, lit_len_in;
   logic             lit_ovf_ff, lit_ovf_in;
   logic             pw_valid_ff, pw_valid_in;
   logic [7:0]       pw_byte_ff, pw_byte_in;

   logic [7:0]    b;
   logic          eop;
   logic          is_digit, is_quote, is_bslash, is_lower, is_upper;
   logic          p_emit;
   logic [4:0]    p_kind;
   logic [15:0]   p_val;
   logic          plain_path;
   logic [15:0]   digit_val;
   logic [19:0]   num_wide;
   logic          num_sat;
   logic [15:0]   num_next;
   logic          pre_v, main_v, burst;
   rpl_pkg::rsp_type pre_tok, main_tok;
   logic          app_en;
   logic [7:0]    app_byte;

   function automatic rpl_pkg::rsp_type make_tok(
      input logic [4:0]  kind,
      input logic [PW-1:0] s,
      input logic [PW-1:0] e,
      input logic [15:0] val,
      input logic [2:0]  err
   );
      rpl_pkg::rsp_type t;
      t.token_kind  = kind;
      t.start_pos   = s;
      t.end_pos     = e;
      t.token_value = val;
      t.error_code  = err;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   function automatic rpl_pkg::rsp_type make_err(
      input logic [PW-1:0] s,
      input logic [PW-1:0] e,
      input logic [2:0]  code
   );
      return make_tok(rpl_pkg::KIND_ERROR, s, e, 16'(code), code);
   endfunction

   assign b   = req.pattern_byte;
   assign eop = req.end_of_pattern;

   // Multiply by ten as two shifts and an add, then saturate.
   assign digit_val = 16'(b[3:0]);
   assign num_wide  = 20'({acc_ff, 3'b000}) + 20'({acc_ff, 1'b0}) + 20'(digit_val);
   assign num_sat   = |num_wide[19:16];
   assign num_next  = num_sat ? 16'hFFFF : num_wide[15:0];

   always_comb begin : classify
      is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
      is_lower  = (b >= CH_LOW_A) && (b <= CH_LOW_Z);
      is_upper  = (b >= CH_UP_A) && (b <= CH_UP_Z);
      is_quote  = (b == CH_QUOTE);
      is_bslash = (b == CH_BSLASH);
      p_emit = 1'b1;
      p_kind = rpl_pkg::KIND_UNKNOWN;
      p_val  = 16'd0;
      unique case (b)
         CH_QUOTE, CH_BSLASH: p_emit = 1'b0;
         CH_SPACE: begin
            p_kind = rpl_pkg::KIND_SPACE;
            p_emit = !skip_blanks;
         end
         CH_TAB: begin
            p_kind = rpl_pkg::KIND_TAB;
            p_emit = !skip_blanks;
         end
         CH_PLUS:   p_kind = rpl_pkg::KIND_PLUS;
         CH_STAR:   p_kind = rpl_pkg::KIND_STAR;
         CH_QMARK:  p_kind = rpl_pkg::KIND_QUESTION;
         CH_MINUS:  p_kind = rpl_pkg::KIND_MINUS;
         CH_LBRACK: p_kind = rpl_pkg::KIND_LBRACK;
         CH_RBRACK: p_kind = rpl_pkg::KIND_RBRACK;
         CH_LPAREN: p_kind = rpl_pkg::KIND_LPAREN;
         CH_RPAREN: p_kind = rpl_pkg::KIND_RPAREN;
         CH_LCURLY: p_kind = rpl_pkg::KIND_LCURLY;
         CH_RCURLY: p_kind = rpl_pkg::KIND_RCURLY;
         CH_COMMA:  p_kind = rpl_pkg::KIND_COMMA;
         CH_BANG:   p_kind = rpl_pkg::KIND_BANG;
         CH_BAR:    p_kind = rpl_pkg::KIND_OR;
         default: begin
            priority if (is_lower) begin
               p_kind = rpl_pkg::KIND_LOWER;
               p_val  = 16'(b);
            end else if (is_upper) begin
               p_kind = rpl_pkg::KIND_UPPER;
               p_val  = 16'(b);
            end else if (is_digit) begin
               p_emit = 1'b0;
            end else begin
               p_val = 16'(b);
            end
         end
      endcase
      // Idle mode, or a number run that this byte ends.
      plain_path = (mode_ff == rpl_pkg::MODE_IDLE) ||
                   ((mode_ff == rpl_pkg::MODE_NUM) && !is_digit);
   end

   // Next lexer mode.
   always_comb begin : next_mode
      rpl_pkg::lex_mode_type plain_mode;
      priority if (is_quote) begin
         plain_mode = rpl_pkg::MODE_LIT;
      end else if (is_bslash) begin
         plain_mode = rpl_pkg::MODE_ESC;
      end else if (is_digit) begin
         plain_mode = rpl_pkg::MODE_NUM;
      end else begin
         plain_mode = rpl_pkg::MODE_IDLE;
      end
      mode_in = mode_ff;
      if (accept) begin
         unique case (mode_ff)
            rpl_pkg::MODE_NUM: mode_in = is_digit ? rpl_pkg::MODE_NUM : plain_mode;
            rpl_pkg::MODE_ESC: mode_in = rpl_pkg::MODE_IDLE;
            rpl_pkg::MODE_LIT: begin
               priority if (is_bslash) begin
                  mode_in = rpl_pkg::MODE_LITESC;
               end else if (is_quote) begin
                  mode_in = rpl_pkg::MODE_IDLE;
               end else begin
                  mode_in = rpl_pkg::MODE_LIT;
               end
            end
            rpl_pkg::MODE_LITESC: mode_in = rpl_pkg::MODE_LIT;
            default: mode_in = plain_mode;
         endcase
         if (eop) begin
            mode_in = rpl_pkg::MODE_IDLE;
         end
      end
   end

   // Tokens caused by the byte at the request port.
   always_comb begin : tokens
      pre_v   = (mode_ff == rpl_pkg::MODE_NUM) && !is_digit;
      pre_tok = make_tok(rpl_pkg::KIND_NUMBER, start_ff, num_end_ff, acc_ff,
                         num_ovf_ff ? rpl_pkg::ERR_NUM_SAT : rpl_pkg::ERR_NONE);
      main_v   = 1'b0;
      main_tok = make_tok(p_kind, pos_ff, pos_ff, p_val, rpl_pkg::ERR_NONE);
      burst    = 1'b0;
      if (plain_path) begin
         priority if (p_emit) begin
            main_v = 1'b1;
         end else if (eop && is_bslash) begin
            // Backslash as the last byte of the pattern.
            main_v   = 1'b1;
            main_tok = make_err(pos_ff, pos_ff, rpl_pkg::ERR_BAD_ESCAPE);
         end else if (eop && is_quote) begin
            main_v   = 1'b1;
            main_tok = make_err(pos_ff, pos_ff, rpl_pkg::ERR_UNTERMINATED);
         end else if (eop && is_digit) begin
            main_v   = 1'b1;
            main_tok = make_tok(rpl_pkg::KIND_NUMBER, pos_ff, pos_ff, digit_val,
                                rpl_pkg::ERR_NONE);
         end else begin
            main_v = 1'b0;
         end
      end else begin
         unique case (mode_ff)
            rpl_pkg::MODE_NUM: begin
               main_v   = eop;
               main_tok = make_tok(rpl_pkg::KIND_NUMBER, start_ff, pos_ff, num_next,
                                   (num_ovf_ff || num_sat) ? rpl_pkg::ERR_NUM_SAT
                                                           : rpl_pkg::ERR_NONE);
            end
            rpl_pkg::MODE_ESC: begin
               main_v = 1'b1;
               unique case (b)
                  CH_LOW_C: main_tok = make_tok(rpl_pkg::KIND_CHAR, start_ff, pos_ff,
                                                16'd0, rpl_pkg::ERR_NONE);
                  CH_UP_C:  main_tok = make_tok(rpl_pkg::KIND_BIG_CHAR, start_ff, pos_ff,
                                                16'd0, rpl_pkg::ERR_NONE);
                  CH_UP_T:  main_tok = make_tok(rpl_pkg::KIND_ANY_CHAR, start_ff, pos_ff,
                                                16'd0, rpl_pkg::ERR_NONE);
                  CH_LOW_D: main_tok = make_tok(rpl_pkg::KIND_DIGIT, start_ff, pos_ff,
                                                16'd0, rpl_pkg::ERR_NONE);
                  CH_LOW_N: main_tok = make_tok(rpl_pkg::KIND_NEWLINE, start_ff, pos_ff,
                                                16'd0, rpl_pkg::ERR_NONE);
                  CH_UP_A:  main_tok = make_tok(rpl_pkg::KIND_ANY, start_ff, pos_ff,
                                                16'd0, rpl_pkg::ERR_NONE);
                  default:  main_tok = make_err(start_ff, pos_ff, rpl_pkg::ERR_BAD_ESCAPE);
               endcase
            end
            rpl_pkg::MODE_LIT: begin
               priority if (is_quote) begin
                  main_v = 1'b1;
                  if (lit_ovf_ff) begin
                     main_tok = make_err(start_ff, pos_ff, rpl_pkg::ERR_LIT_OVERFLOW);
                  end else begin
                     main_tok = make_tok(rpl_pkg::KIND_LIT_HEAD, start_ff, pos_ff,
                                         16'(lit_len_ff), rpl_pkg::ERR_NONE);
                     burst    = (lit_len_ff != '0);
                  end
               end else if (eop) begin
                  main_v   = 1'b1;
                  main_tok = make_err(start_ff, pos_ff, rpl_pkg::ERR_UNTERMINATED);
               end else begin
                  main_v = 1'b0;
               end
            end
            rpl_pkg::MODE_LITESC: begin
               main_v   = eop;
               main_tok = make_err(start_ff, pos_ff, rpl_pkg::ERR_UNTERMINATED);
            end
            default: main_v = 1'b0;
         endcase
      end

      lex.count       = 2'(pre_v) + 2'(main_v);
      lex.tok0        = pre_v ? pre_tok : main_tok;
      lex.tok1        = main_tok;
      lex.burst       = burst;
      lex.burst_len   = lit_len_ff;
      lex.burst_start = start_ff;
      lex.burst_end   = pos_ff;
      // The last token of the byte carries the run flag unless literal items follow.
      if (!burst) begin
         if (pre_v && main_v) begin
            lex.tok1.last_of_run = 1'b1;
         end else begin
            lex.tok0.last_of_run = 1'b1;
         end
      end
   end

   // Scanner registers and literal buffer writes.
   always_comb begin : update
      start_in    = start_ff;
      acc_in      = acc_ff;
      num_ovf_in  = num_ovf_ff;
      num_end_in  = num_end_ff;
      lit_len_in  = lit_len_ff;
      lit_ovf_in  = lit_ovf_ff;
      pos_in      = pos_ff;
      pw_valid_in = 1'b0;
      pw_byte_in  = pw_byte_ff;
      app_en      = 1'b0;
      app_byte    = b;
      if (pw_valid_ff) begin
         // Second byte of an unrecognized escape inside a literal.
         app_en   = 1'b1;
         app_byte = pw_byte_ff;
      end else if (accept) begin
         if (plain_path) begin
            if (is_quote) begin
               start_in   = pos_ff;
               lit_len_in = '0;
               lit_ovf_in = 1'b0;
            end else if (is_bslash) begin
               start_in = pos_ff;
            end else if (is_digit) begin
               start_in   = pos_ff;
               acc_in     = digit_val;
               num_ovf_in = 1'b0;
               num_end_in = pos_ff;
            end
         end else begin
            unique case (mode_ff)
               rpl_pkg::MODE_NUM: begin
                  acc_in     = num_next;
                  num_ovf_in = num_ovf_ff || num_sat;
                  num_end_in = pos_ff;
               end
               rpl_pkg::MODE_LIT: app_en = !is_bslash && !is_quote;
               rpl_pkg::MODE_LITESC: begin
                  app_en = 1'b1;
                  if (!is_quote && !is_bslash) begin
                     app_byte    = CH_BSLASH;
                     pw_valid_in = !eop;
                     pw_byte_in  = b;
                  end
               end
               default: app_en = 1'b0;
            endcase
         end
      end

      ram_wr.en   = 1'b0;
      ram_wr.addr = lit_len_ff[IDX_W-1:0];
      ram_wr.data = app_byte;
      if (app_en) begin
         if (lit_len_ff < LEN_MAX) begin
            ram_wr.en  = 1'b1;
            lit_len_in = lit_len_ff + 1'b1;
         end else begin
            lit_ovf_in = 1'b1;
         end
      end

      if (accept) begin
         if (eop) begin
            pos_in      = '0;
            start_in    = '0;
            acc_in      = '0;
            num_ovf_in  = 1'b0;
            num_end_in  = '0;
            lit_len_in  = '0;
            lit_ovf_in  = 1'b0;
         end else if (pos_ff < rpl_pkg::POS_CAP) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= rpl_pkg::MODE_IDLE;
         pos_ff      <= '0;
         start_ff    <= '0;
         acc_ff      <= '0;
         num_ovf_ff  <= 1'b0;
         num_end_ff  <= '0;
         lit_len_ff  <= '0;
         lit_ovf_ff  <= 1'b0;
         pw_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         acc_ff      <= acc_in;
         num_ovf_ff  <= num_ovf_in;
         num_end_ff  <= num_end_in;
         lit_len_ff  <= lit_len_in;
         lit_ovf_ff  <= lit_ovf_in;
         pw_valid_ff <= pw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pw_byte_ff <= pw_byte_in;
   end

   assign status.busy = pw_valid_ff;
   assign status.mode = mode_ff;
   assign status.pos  = pos_ff;

endmodule

FILE: hdl/rpl_emit.sv
// ----------------------------------------------------------------------------
// rpl_emit: response sequencer of the regex pattern lexer
// Holds the response register and one pending token, and streams the
// buffered bytes of a closed literal out of the literal buffer RAM.
// ----------------------------------------------------------------------------
module rpl_emit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  rpl_pkg::lex_result_type              lex,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output rpl_pkg::rsp_type                     rsp_data,
   output logic                                 ram_rd_en,
   output logic [rpl_pkg::LIT_IDX_W-1:0]        ram_rd_addr,
   input  logic [7:0]                           ram_rd_data,
   output rpl_pkg::emit_status_type             status
);

   localparam int LEN_W = rpl_pkg::LIT_LEN_W;
   localparam int PW    = rpl_pkg::POS_W;

   logic             out_valid_ff, out_valid_in;
   rpl_pkg::rsp_type out_ff, out_in;
   logic             pend_valid_ff, pend_valid_in;
   rpl_pkg::rsp_type pend_ff, pend_in;
   logic [LEN_W-1:0] rd_left_ff, rd_left_in;
   logic [rpl_pkg::LIT_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             item_valid_ff, item_valid_in;
   logic             item_last_ff, item_last_in;
   logic [PW-1:0]    bstart_ff, bstart_in;
   logic [PW-1:0]    bend_ff, bend_in;

   logic             out_free;
   logic             item_take;
   rpl_pkg::rsp_type item_tok;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign item_take = item_valid_ff && !pend_valid_ff && out_free;
   assign ram_rd_en = (rd_left_ff != '0) && (!item_valid_ff || item_take);
   assign ram_rd_addr = rd_idx_ff;

   always_comb begin
      item_tok.token_kind  = rpl_pkg::KIND_LIT_BYTE;
      item_tok.start_pos   = bstart_ff;
      item_tok.end_pos     = bend_ff;
      item_tok.token_value = 16'(ram_rd_data);
      item_tok.error_code  = rpl_pkg::ERR_NONE;
      item_tok.last_of_run = item_last_ff;
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rd_left_in    = rd_left_ff;
      rd_idx_in     = rd_idx_ff;
      bstart_in     = bstart_ff;
      bend_in       = bend_ff;
      item_valid_in = item_valid_ff;
      item_last_in  = item_last_ff;

      priority if (accept) begin
         out_valid_in  = (lex.count != 2'd0);
         out_in        = lex.tok0;
         pend_valid_in = (lex.count == 2'd2);
         pend_in       = lex.tok1;
         rd_left_in    = lex.burst ? lex.burst_len : '0;
         rd_idx_in     = '0;
         bstart_in     = lex.burst_start;
         bend_in       = lex.burst_end;
      end else if (out_free) begin
         priority if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = pend_ff;
            pend_valid_in = 1'b0;
         end else if (item_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = item_tok;
         end else begin
            out_valid_in = 1'b0;
         end
      end else begin
         // The response register holds while the receiver stalls.
         out_valid_in = out_valid_ff;
      end

      if (ram_rd_en) begin
         item_valid_in = 1'b1;
         item_last_in  = (rd_left_ff == LEN_W'(1));
         rd_left_in    = rd_left_ff - 1'b1;
         rd_idx_in     = rd_idx_ff + 1'b1;
      end else if (item_take) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rd_left_ff    <= '0;
         item_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         rd_left_ff    <= rd_left_in;
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff       <= out_in;
      pend_ff      <= pend_in;
      rd_idx_ff    <= rd_idx_in;
      item_last_ff <= item_last_in;
      bstart_ff    <= bstart_in;
      bend_ff      <= bend_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_ff;
   assign status.out_free = out_free;
   assign status.idle     = !pend_valid_ff && (rd_left_ff == '0) && !item_valid_ff;

endmodule

FILE: hdl/regex_pattern_lexer_top.sv
// ----------------------------------------------------------------------------
// regex_pattern_lexer_top: streaming lexer for regex patterns
// Takes pattern text one byte per request and produces tokens with kind,
// positions, value and error code; quoted literals are buffered in a RAM.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_stall   rpl_pkg::req_type (byte, end mark)
// rsp      out  rsp_valid/rsp_stall   rpl_pkg::rsp_type (one token)
// csr      in   csr_wr_en             csr_wr_data (skip_blanks)
//
// A request yielding at most one token leaves req_stall low, so plain text
// streams at one byte per cycle while rsp_stall is low. A request with two
// tokens (a number run ended by a token byte) parks the second one, and an
// unknown escape in a literal writes two bytes in turn, since the literal
// buffer RAM has one write port. A closed literal's items are read back from
// the RAM one per cycle, unless stalled, behind its registered read port.
// Reset is synchronous and clears all control state; the RAM is not
// cleared, as only entries written in the current literal are read back.
// req_stall rises while the response register is held by rsp_stall, while
// tokens or literal items of the previous request are still queued, and
// during the second RAM write of an escape.
//
module regex_pattern_lexer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rpl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rpl_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   logic                     skip_blanks_ff, skip_blanks_in;
   logic                     req_accept;
   rpl_pkg::lex_result_type  lex;
   rpl_pkg::ram_wr_type      ram_wr;
   rpl_pkg::scan_status_type scan_st;
   rpl_pkg::emit_status_type emit_st;
   logic                     ram_rd_en;
   logic [rpl_pkg::LIT_IDX_W-1:0] ram_rd_addr;
   logic [7:0]               ram_rd_data;

   // Configuration register.
   assign skip_blanks_in = csr_wr_en ? csr_wr_data : skip_blanks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_blanks_ff <= 1'b0;
      end else begin
         skip_blanks_ff <= skip_blanks_in;
      end
   end

   // A request is taken only when no escape byte waits, all tokens of the
   // last one have moved on and the response register is free in this cycle.
   assign req_stall  = scan_st.busy || !emit_st.idle || !emit_st.out_free;
   assign req_accept = req_valid && !req_stall;

   rpl_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req         (req_data),
      .skip_blanks (skip_blanks_ff),
      .lex         (lex),
      .ram_wr      (ram_wr),
      .status      (scan_st)
   );

   // Literal buffer: written by the scanner, read back by the emitter when
   // the literal closes. Requests are held off during the read-back, so the
   // two ports never touch the same entry in one cycle.
   rpl_ram #(
      .Width (8),
      .Depth (rpl_pkg::MAX_LITERAL)
   ) u_lit_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rpl_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .lex         (lex),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .status      (emit_st)
   );

   // The end of a pattern brings the scanner back to idle at position zero.
   a_eop_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.end_of_pattern) |=>
         (scan_st.mode == rpl_pkg::MODE_IDLE) && (scan_st.pos == '0))
      else $error("scanner not idle after end of pattern");

   // A literal read-back only follows a lone header token.
   a_burst_single_head: assert property (@(posedge clock) disable iff (reset)
      (req_accept && lex.burst) |->
         (lex.count == 2'd1) && (lex.tok0.token_kind == rpl_pkg::KIND_LIT_HEAD))
      else $error("literal read-back without a lone header");

   // Literal items stream without gaps once the first one is out.
   a_items_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && (rsp_data.token_kind == rpl_pkg::KIND_LIT_BYTE) &&
       !rsp_data.last_of_run) |=>
         (rsp_valid && (rsp_data.token_kind == rpl_pkg::KIND_LIT_BYTE)))
      else $error("gap in literal item stream");

endmodule
